// ===== hdl/stadpcm_pkg.sv =====
`default_nettype none

package stadpcm_pkg;

  // Channel and code widths
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 7;
  localparam int STEP_W   = 15;
  localparam int CODE_W   = 4;
  localparam int BYTE_W   = 8;

  localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;

  // Header beat positions; the others carry zero
  localparam logic [2:0] HDR_LEFT_HI  = 3'd0;
  localparam logic [2:0] HDR_LEFT_LO  = 3'd1;
  localparam logic [2:0] HDR_RIGHT_HI = 3'd4;
  localparam logic [2:0] HDR_RIGHT_LO = 3'd5;
  localparam logic [2:0] HDR_FINAL    = 3'd7;

  // Lane control from the merge stage
  typedef struct packed {
    logic advance;  // frame accepted
    logic load;     // frame opens a block
  } lane_ctl_t;

  // IMA ADPCM step sizes
  localparam logic [STEP_W-1:0] IMA_STEP_SIZES [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Step index adjustment by code magnitude
  function automatic logic signed [7:0] index_adjust(input logic [2:0] mag);
    logic signed [7:0] adj;
    case (mag)
      3'd4:    adj = 8'sd2;
      3'd5:    adj = 8'sd4;
      3'd6:    adj = 8'sd6;
      3'd7:    adj = 8'sd8;
      default: adj = -8'sd1;
    endcase
    return adj;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stadpcm_lane.sv =====
`default_nettype none

module stadpcm_lane (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic signed [stadpcm_pkg::SAMPLE_W-1:0] sample,
  input  wire stadpcm_pkg::lane_ctl_t               ctl,
  output      logic [stadpcm_pkg::CODE_W-1:0]       code
);
  import stadpcm_pkg::*;

  logic signed [SAMPLE_W-1:0] predictor;
  logic signed [SAMPLE_W-1:0] predictor_next;
  logic [INDEX_W-1:0]         step_index;
  logic [INDEX_W-1:0]         step_index_next;

  logic [INDEX_W-1:0]         idx_c;
  logic [STEP_W:0]            step;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag0;
  logic [SAMPLE_W:0]          mag1;
  logic [SAMPLE_W:0]          mag2;
  logic [SAMPLE_W:0]          step_w;
  logic [SAMPLE_W:0]          half_w;
  logic [SAMPLE_W:0]          quarter_w;
  logic [SAMPLE_W:0]          recon;
  logic signed [SAMPLE_W+1:0] pred_sum;
  logic signed [7:0]          idx_sum;

  // Quantise the prediction error against the current step
  always_comb begin
    idx_c     = (step_index > INDEX_MAX) ? INDEX_MAX : step_index;
    step      = {1'b0, IMA_STEP_SIZES[idx_c]};
    step_w    = {1'b0, step};
    half_w    = {2'b00, step[STEP_W:1]};
    quarter_w = {3'b000, step[STEP_W:2]};
    diff      = {sample[SAMPLE_W-1], sample} - {predictor[SAMPLE_W-1], predictor};
    code      = '0;
    code[3]   = diff[SAMPLE_W];
    mag0      = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    recon     = {4'b0000, step[STEP_W:3]};
    mag1      = mag0;
    if (mag0 >= step_w) begin
      code[2] = 1'b1;
      mag1    = mag0 - step_w;
      recon   = recon + step_w;
    end
    mag2 = mag1;
    if (mag1 >= half_w) begin
      code[1] = 1'b1;
      mag2    = mag1 - half_w;
      recon   = recon + half_w;
    end
    if (mag2 >= quarter_w) begin
      code[0] = 1'b1;
      recon   = recon + quarter_w;
    end
  end

  // Reconstruct the predictor and adapt the step index, both clamped
  always_comb begin
    if (code[3]) begin
      pred_sum = {{2{predictor[SAMPLE_W-1]}}, predictor} - {1'b0, recon};
    end else begin
      pred_sum = {{2{predictor[SAMPLE_W-1]}}, predictor} + {1'b0, recon};
    end
    if (pred_sum < -18'sd32768) begin
      predictor_next = 16'sh8000;
    end else if (pred_sum > 18'sd32767) begin
      predictor_next = 16'sh7FFF;
    end else begin
      predictor_next = pred_sum[SAMPLE_W-1:0];
    end

    idx_sum = $signed({1'b0, idx_c}) + index_adjust(code[2:0]);
    if (idx_sum < 8'sd0) begin
      step_index_next = '0;
    end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
      step_index_next = INDEX_MAX;
    end else begin
      step_index_next = idx_sum[INDEX_W-1:0];
    end
  end

  // Hold channel state; update it on each accepted frame and reload it at the start of a block
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor  <= '0;
      step_index <= '0;
    end else if (ctl.advance) begin
      if (ctl.load) begin
        predictor  <= sample;
        step_index <= '0;
      end else begin
        predictor  <= predictor_next;
        step_index <= step_index_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stadpcm_merge.sv =====
`default_nettype none

module stadpcm_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output      logic                                  in_ready,
  input  wire logic                                  first_frame,
  input  wire logic [stadpcm_pkg::SAMPLE_W-1:0]      left_sample,
  input  wire logic [stadpcm_pkg::SAMPLE_W-1:0]      right_sample,
  input  wire logic [stadpcm_pkg::CODE_W-1:0]        left_nibble,
  input  wire logic [stadpcm_pkg::CODE_W-1:0]        right_nibble,
  output      stadpcm_pkg::lane_ctl_t                ctl,
  output      logic                                  out_valid,
  input  wire logic                                  out_ready,
  output      logic [stadpcm_pkg::BYTE_W-1:0]        out_byte,
  output      logic                                  out_last
);
  import stadpcm_pkg::*;

  logic                hdr_active;
  logic [2:0]          hdr_cnt;
  logic [SAMPLE_W-1:0] hdr_left;
  logic [SAMPLE_W-1:0] hdr_right;
  logic                slot_free;
  logic                accept;
  logic [BYTE_W-1:0]   hdr_byte;

  // Output register frees when empty or being taken
  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = !hdr_active && slot_free;
  assign accept      = in_valid && in_ready;
  assign ctl.advance = accept;
  assign ctl.load    = first_frame;

  // Select the pending header byte
  always_comb begin
    case (hdr_cnt)
      HDR_LEFT_HI:  hdr_byte = hdr_left[15:8];
      HDR_LEFT_LO:  hdr_byte = hdr_left[7:0];
      HDR_RIGHT_HI: hdr_byte = hdr_right[15:8];
      HDR_RIGHT_LO: hdr_byte = hdr_right[7:0];
      default:      hdr_byte = '0;
    endcase
  end

  // Control: output valid and header sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hdr_active <= 1'b0;
      hdr_cnt    <= '0;
    end else if (accept) begin
      out_valid <= 1'b1;
      if (first_frame) begin
        hdr_active <= 1'b1;
        hdr_cnt    <= HDR_LEFT_LO;
      end
    end else if (hdr_active && slot_free) begin
      out_valid <= 1'b1;
      hdr_cnt   <= hdr_cnt + 3'd1;
      if (hdr_cnt == HDR_FINAL) begin
        hdr_active <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload: code byte, header bytes and the captured samples
  always_ff @(posedge clk) begin
    if (accept) begin
      if (first_frame) begin
        hdr_left  <= left_sample;
        hdr_right <= right_sample;
        out_byte  <= left_sample[15:8];
        out_last  <= 1'b0;
      end else begin
        out_byte <= {right_nibble, left_nibble};
        out_last <= 1'b1;
      end
    end else if (hdr_active && slot_free) begin
      out_byte <= hdr_byte;
      out_last <= (hdr_cnt == HDR_FINAL);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stereo_adpcm_encoder_top.sv =====
// A frame's first output beat is registered and valid in the cycle after the frame is accepted.
// Throughput: one coded frame per cycle while the output side keeps taking beats;
// the 4-bit quantiser in each channel lane is combinational.
// A first frame yields eight header beats and holds input off until the last of them
// is registered, longer while the output side stalls.
// Reset (rst, synchronous, active high) clears both predictors and step indices to
// zero and empties the output register.
`default_nettype none

module stereo_adpcm_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] left_sample, [31:16] right_sample
  input  wire logic        s_tuser,   // [0] first_frame
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,   // [7:0] code_byte or header byte
  output      logic        m_tlast    // last_byte
);
  import stadpcm_pkg::*;

  lane_ctl_t         ctl;
  logic [CODE_W-1:0] left_nibble;
  logic [CODE_W-1:0] right_nibble;

  // Left channel lane
  stadpcm_lane u_left (
    .clk    (clk),
    .rst    (rst),
    .sample ($signed(s_tdata[15:0])),
    .ctl    (ctl),
    .code   (left_nibble)
  );

  // Right channel lane
  stadpcm_lane u_right (
    .clk    (clk),
    .rst    (rst),
    .sample ($signed(s_tdata[31:16])),
    .ctl    (ctl),
    .code   (right_nibble)
  );

  // Pack codes, serialise headers, drive the output beat
  stadpcm_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .first_frame  (s_tuser),
    .left_sample  (s_tdata[15:0]),
    .right_sample (s_tdata[31:16]),
    .left_nibble  (left_nibble),
    .right_nibble (right_nibble),
    .ctl          (ctl),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_byte     (m_tdata),
    .out_last     (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/stadpcm_checker.sv =====
`default_nettype none

module stadpcm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  // Output register is empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid straight after reset");

  // A block-opening frame starts a header: input held off, first beat not last
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> (!s_tready && m_tvalid && !m_tlast))
    else $error("header did not start after first frame");

  // A coded frame gives one beat, marked last, on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> (m_tvalid && m_tlast))
    else $error("coded frame beat missing or not last");

  // A stalled beat holds its payload
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output beat changed");

endmodule

bind stereo_adpcm_encoder_top stadpcm_checker u_checker (.*);

`default_nettype wire
